/* rtl/core/servo_swing_turn_profiler_assert.svh */
// Assertion macros shared by the servo swing and turn profiler RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SERVO_SWING_TURN_PROFILER_ASSERT_SVH
`define SERVO_SWING_TURN_PROFILER_ASSERT_SVH

// The expression holds at every clock edge.
`define SSTP_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SSTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sstp_pkg.sv */
// Package for the servo swing and turn profiler: command and register codes,
// sequencer states, divider interface types and the quarter-wave sine function.
// It depends on nothing else.
package sstp_pkg;

  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_SET_ANGLE   = 3'd1;
  localparam logic [2:0] CMD_START_SWING = 3'd2;
  localparam logic [2:0] CMD_START_TURN  = 3'd3;
  localparam logic [2:0] CMD_STOP        = 3'd4;

  localparam logic [2:0] REG_LOWER_LIMIT   = 3'd0;
  localparam logic [2:0] REG_UPPER_LIMIT   = 3'd1;
  localparam logic [2:0] REG_WAVE_SHAPE    = 3'd2;
  localparam logic [2:0] REG_MOTION_PERIOD = 3'd3;
  localparam logic [2:0] REG_SWING_CYCLES  = 3'd4;
  localparam logic [2:0] REG_SWING_AMP     = 3'd5;
  localparam logic [2:0] REG_AMP_GROWTH    = 3'd6;
  localparam logic [2:0] REG_DIR_POSITIVE  = 3'd7;

  localparam int DivNW = 56;
  localparam int DivDW = 28;
  localparam int DivCntW = $clog2(DivNW + 1);

  localparam logic [63:0] PiQ30 = 64'd3373259426;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quotient;
    logic [DivDW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SW_TOTAL,
    ST_SW_CLIP,
    ST_SW_MOD,
    ST_SW_MOD_W,
    ST_SW_PH,
    ST_SW_PH_W,
    ST_SW_TRI,
    ST_SW_ROM,
    ST_SW_SMUL,
    ST_SW_SSHIFT,
    ST_SW_GW,
    ST_SW_DEC,
    ST_SW_GM_LO,
    ST_SW_GM_HI,
    ST_SW_GDIV,
    ST_SW_GDIV_W,
    ST_SW_FIN,
    ST_TU_DIV,
    ST_TU_DIV_W,
    ST_TU_FIN,
    ST_DONE
  } sstp_state_e;

  // Quarter-wave sine in Q1.15 by a truncated Taylor series; the table depth
  // is a power of two given by its logarithm.
  function automatic logic [15:0] sine_q15(input int unsigned idx,
                                           input int unsigned log_depth);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] q;
    logic signed [63:0] sum;
    x    = (64'(idx) * PiQ30) >> (log_depth + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = (unsigned'(sum) + 64'd16384) >> 15;
    if (q > 64'd32768) begin
      q = 64'd32768;
    end
    return q[15:0];
  endfunction

endpackage

/* rtl/core/sstp_div.sv */
// Iterative restoring divider shared by every division of the profiler.
// One quotient bit per cycle; depends on sstp_pkg for widths and types.
module sstp_div import sstp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNW-1:0]   quot_q, quot_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivDW-1:0]   dsr_q, dsr_d;
  logic [DivDW:0]     shifted;
  logic [DivDW:0]     diff;
  logic               fits;

  assign shifted = {rem_q, quot_q[DivNW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNW);
      quot_d = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[DivNW-2:0], fits};
      rem_d  = fits ? diff[DivDW-1:0] : shifted[DivDW-1:0];
      cnt_d  = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/core/servo_swing_turn_profiler.sv */
// Channel  Dir  Payload (lowest bit first)                    Accepted when
// s_axis   in   command[2:0], target_angle[18:3]               tvalid && tready
// m_axis   out  servo_angle[15:0], motion_active[16]           tvalid && tready
// cfg      in   cfg_index_i selects register, cfg_data_i value cfg_valid_i && cfg_ready_o
// Set angle, start, stop and unused commands, and a tick with no motion running, go from acceptance
// through ST_DONE to their result. A turn tick runs ST_TU_DIV, the divider, ST_TU_FIN and ST_DONE,
// or goes from ST_TU_DIV to ST_DONE with a zero period. A swing tick with a zero period ends after
// ST_SW_CLIP; otherwise the 56-step shared divider runs three times in it.
// Reset is asynchronous; it sets the control and output registers, but not the datapath registers.
// A new transaction is taken only once the previous result has been taken.
// Top level of the profiler; depends on sstp_pkg, sstp_div and the assert header.
`include "servo_swing_turn_profiler_assert.svh"

module servo_swing_turn_profiler import sstp_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[2:0], target_angle[18:3], zero fill[23:19]
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // servo_angle[15:0], motion_active[16], zero fill[23:17]
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int LogD = $clog2(SINE_TABLE_DEPTH);
  localparam int IdxW = LogD + 1;

  typedef logic [15:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      rom[i] = sine_q15(i, LogD);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  sstp_state_e state_q, state_d;

  logic        [8:0]  lower_q, upper_q;
  logic               shape_q, dirpos_q;
  logic        [15:0] period_q, cycles_q, growth_q;
  logic signed [12:0] amp_q;

  logic        [31:0] elapsed_q;
  logic signed [15:0] start_q, current_q;
  logic               swing_q, turn_q, m_valid_q;

  logic        [31:0] t_q;
  logic        [31:0] total_q;
  logic        [15:0] m_q;
  logic signed [15:0] d_q;
  logic        [15:0] s_q;
  logic               sneg_q;
  logic signed [30:0] prod_q;
  logic signed [43:0] w_q;
  logic               decay_q;
  logic        [36:0] plo_q;
  logic [DivNW-1:0]   num_q;
  logic               num_neg_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        [8:0]  lim_lo, lim_hi;
  logic        [2:0]  cmd;
  logic signed [16:0] tgt_ext, lo_ext, hi_ext, tgt_clamp;
  logic               accept;
  logic        [31:0] elapsed_inc;
  logic               over_total;
  logic        [12:0] amp_mag;
  logic        [29:0] tri_prod;
  logic        [15:0] qmag;
  logic signed [15:0] qs, a16, tri_d;
  logic        [17:0] three_p;
  logic        [IdxW:0] ph;
  logic        [IdxW-1:0] rom_idx;
  logic signed [13:0] a_ext, a_adj, a_half;
  logic signed [16:0] s_sgn;
  logic signed [30:0] sine_prod, sine_adj;
  logic signed [16:0] g_off;
  logic signed [24:0] t24s;
  logic signed [41:0] gt;
  logic signed [43:0] w_d;
  logic        [12:0] dec_fac;
  logic        [36:0] dec_prod;
  logic        [15:0] d_mag;
  logic        [41:0] w_mag;
  logic        [36:0] p_lo, p_hi;
  logic signed [57:0] dg, dg_dir, ang_sum;
  logic signed [15:0] swing_angle;
  logic        [40:0] turn_dvd;
  logic signed [43:0] turn_a, lo44, hi44;
  logic               div_wait;

  assign lim_lo = (lower_q < upper_q) ? lower_q : upper_q;
  assign lim_hi = (lower_q > upper_q) ? lower_q : upper_q;

  assign cmd     = s_axis_tdata_i[2:0];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign tgt_ext = 17'(signed'(s_axis_tdata_i[18:3]));
  assign lo_ext  = signed'({8'b0, lim_lo});
  assign hi_ext  = signed'({8'b0, lim_hi});
  assign tgt_clamp = (tgt_ext < lo_ext) ? lo_ext : ((tgt_ext > hi_ext) ? hi_ext : tgt_ext);

  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
  assign over_total  = {t_q, 8'b0} > {8'b0, total_q};

  // Triangle wave
  assign amp_mag  = amp_q[12] ? 13'(-amp_q) : 13'(amp_q);
  assign tri_prod = {amp_mag, 1'b0} * m_q;
  assign qmag     = div_rsp.quotient[15:0];
  assign qs       = amp_q[12] ? -signed'(qmag) : signed'(qmag);
  assign a16      = 16'(amp_q);
  assign three_p  = 18'(period_q) * 18'd3;

  always_comb begin
    if (m_q < {2'b0, period_q[15:2]}) begin
      tri_d = qs;
    end else if (m_q < three_p[17:2]) begin
      tri_d = a16 - qs;
    end else begin
      tri_d = qs - (a16 <<< 1);
    end
  end

  // Sine wave
  assign ph      = div_rsp.quotient[IdxW:0];
  assign rom_idx = ph[LogD] ? IdxW'(SINE_TABLE_DEPTH) - {1'b0, ph[LogD-1:0]}
                            : {1'b0, ph[LogD-1:0]};
  assign a_ext     = 14'(amp_q);
  assign a_adj     = amp_q[12] ? a_ext + 14'sd1 : a_ext;
  assign a_half    = a_adj >>> 1;
  assign s_sgn     = sneg_q ? -signed'({1'b0, s_q}) : signed'({1'b0, s_q});
  assign sine_prod = a_half * s_sgn;
  assign sine_adj  = prod_q[30] ? prod_q + 31'sd32767 : prod_q;

  // Growth and decay
  assign g_off    = signed'({1'b0, growth_q}) - 17'sd4096;
  assign t24s     = signed'({1'b0, t_q[23:0]});
  assign gt       = g_off * t24s;
  assign w_d      = signed'(44'({period_q, 12'b0})) + 44'(gt);
  assign dec_fac  = 13'(17'd4096 - {1'b0, growth_q});
  assign dec_prod = dec_fac * t_q[23:0];
  assign d_mag    = d_q[15] ? 16'(-d_q) : 16'(d_q);
  assign w_mag    = w_q[43] ? 42'(-w_q) : 42'(w_q);
  assign p_lo     = d_mag * w_mag[20:0];
  assign p_hi     = d_mag * w_mag[41:21];

  always_comb begin
    dg = num_neg_q ? -signed'({2'b0, div_rsp.quotient}) : signed'({2'b0, div_rsp.quotient});
    if (decay_q) begin
      dg = '0;
    end
    dg_dir  = dirpos_q ? dg : -dg;
    ang_sum = dg_dir + 58'(start_q);
    if (ang_sum > 58'sd32767) begin
      swing_angle = 16'sh7fff;
    end else if (ang_sum < -58'sd32768) begin
      swing_angle = 16'sh8000;
    end else begin
      swing_angle = ang_sum[15:0];
    end
  end

  // Turn ramp
  assign turn_dvd = t_q * 9'd360;
  assign lo44     = signed'({35'b0, lim_lo});
  assign hi44     = signed'({35'b0, lim_hi});
  assign turn_a   = dirpos_q ? 44'(start_q) + signed'({3'b0, div_rsp.quotient[40:0]})
                             : 44'(start_q) - signed'({3'b0, div_rsp.quotient[40:0]});

  assign div_wait = (state_q == ST_SW_MOD_W) || (state_q == ST_SW_PH_W) ||
                    (state_q == ST_SW_GDIV_W) || (state_q == ST_TU_DIV_W);

  sstp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_TICK) begin
            state_d = swing_q ? ST_SW_TOTAL : (turn_q ? ST_TU_DIV : ST_DONE);
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SW_TOTAL:  state_d = ST_SW_CLIP;
      ST_SW_CLIP:   state_d = (period_q == 16'd0) ? ST_DONE : ST_SW_MOD;
      ST_SW_MOD:    state_d = ST_SW_MOD_W;
      ST_SW_MOD_W:  state_d = div_rsp.done ? ST_SW_PH : ST_SW_MOD_W;
      ST_SW_PH:     state_d = ST_SW_PH_W;
      ST_SW_PH_W: begin
        if (div_rsp.done) begin
          state_d = shape_q ? ST_SW_TRI : ST_SW_ROM;
        end
      end
      ST_SW_TRI:    state_d = ST_SW_GW;
      ST_SW_ROM:    state_d = ST_SW_SMUL;
      ST_SW_SMUL:   state_d = ST_SW_SSHIFT;
      ST_SW_SSHIFT: state_d = ST_SW_GW;
      ST_SW_GW:     state_d = ST_SW_DEC;
      ST_SW_DEC:    state_d = ST_SW_GM_LO;
      ST_SW_GM_LO:  state_d = ST_SW_GM_HI;
      ST_SW_GM_HI:  state_d = ST_SW_GDIV;
      ST_SW_GDIV:   state_d = ST_SW_GDIV_W;
      ST_SW_GDIV_W: state_d = div_rsp.done ? ST_SW_FIN : ST_SW_GDIV_W;
      ST_SW_FIN:    state_d = ST_DONE;
      ST_TU_DIV:    state_d = (period_q == 16'd0) ? ST_DONE : ST_TU_DIV_W;
      ST_TU_DIV_W:  state_d = div_rsp.done ? ST_TU_FIN : ST_TU_DIV_W;
      ST_TU_FIN:    state_d = ST_DONE;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o  = (state_q == ST_IDLE) && !m_valid_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DivDW'(period_q);
    unique case (state_q)
      ST_SW_MOD: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivNW'(t_q);
      end
      ST_SW_PH: begin
        div_req.start    = 1'b1;
        div_req.dividend = shape_q ? DivNW'(tri_prod) : (DivNW'(m_q) << (LogD + 2));
      end
      ST_SW_GDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = {period_q, 12'b0};
      end
      ST_TU_DIV: begin
        div_req.start    = (period_q != 16'd0);
        div_req.dividend = DivNW'(turn_dvd);
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, swing_q || turn_q, current_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q   <= 9'd0;
      upper_q   <= 9'd180;
      shape_q   <= 1'b0;
      period_q  <= 16'd1000;
      cycles_q  <= 16'd256;
      amp_q     <= '0;
      growth_q  <= 16'd4096;
      dirpos_q  <= 1'b1;
      state_q   <= ST_IDLE;
      elapsed_q <= '0;
      start_q   <= '0;
      current_q <= '0;
      swing_q   <= 1'b0;
      turn_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_LOWER_LIMIT:   lower_q  <= cfg_data_i[8:0];
          REG_UPPER_LIMIT:   upper_q  <= cfg_data_i[8:0];
          REG_WAVE_SHAPE:    shape_q  <= cfg_data_i[0];
          REG_MOTION_PERIOD: period_q <= cfg_data_i;
          REG_SWING_CYCLES:  cycles_q <= cfg_data_i;
          REG_SWING_AMP:     amp_q    <= signed'(cfg_data_i[12:0]);
          REG_AMP_GROWTH:    growth_q <= cfg_data_i;
          REG_DIR_POSITIVE:  dirpos_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_TICK:      elapsed_q <= elapsed_inc;
              CMD_SET_ANGLE: current_q <= tgt_clamp[15:0];
              CMD_START_SWING: begin
                turn_q <= 1'b0;
                if (!swing_q) begin
                  swing_q   <= 1'b1;
                  elapsed_q <= '0;
                  start_q   <= current_q;
                end
              end
              CMD_START_TURN: begin
                swing_q   <= 1'b0;
                turn_q    <= 1'b1;
                elapsed_q <= '0;
                start_q   <= current_q;
              end
              CMD_STOP: begin
                swing_q <= 1'b0;
                turn_q  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SW_CLIP: begin
          if (over_total || period_q == 16'd0) begin
            swing_q <= 1'b0;
          end
          if (period_q == 16'd0) begin
            current_q <= start_q;
          end
        end
        ST_SW_FIN: current_q <= swing_angle;
        ST_TU_DIV: begin
          if (period_q == 16'd0) begin
            turn_q <= 1'b0;
          end
        end
        ST_TU_FIN: begin
          if (turn_a < lo44) begin
            current_q <= signed'({7'b0, lim_lo});
            turn_q    <= 1'b0;
          end else if (turn_a > hi44) begin
            current_q <= signed'({7'b0, lim_hi});
            turn_q    <= 1'b0;
          end else begin
            current_q <= turn_a[15:0];
          end
        end
        ST_DONE: m_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          t_q <= elapsed_inc;
        end
      end
      ST_SW_TOTAL: total_q <= period_q * cycles_q;
      ST_SW_CLIP: begin
        if (over_total) begin
          t_q <= {8'b0, total_q[31:8]};
        end
      end
      ST_SW_MOD_W: m_q <= div_rsp.remainder[15:0];
      ST_SW_TRI:   d_q <= tri_d;
      ST_SW_ROM: begin
        s_q    <= SineRom[rom_idx];
        sneg_q <= ph[IdxW];
      end
      ST_SW_SMUL:   prod_q  <= sine_prod;
      ST_SW_SSHIFT: d_q     <= 16'(sine_adj >>> 15);
      ST_SW_GW:     w_q     <= w_d;
      ST_SW_DEC:    decay_q <= (growth_q < 16'd4096) && (dec_prod > {9'b0, period_q, 12'b0});
      ST_SW_GM_LO:  plo_q   <= p_lo;
      ST_SW_GM_HI: begin
        num_q     <= DivNW'(plo_q) + (DivNW'(p_hi) << 21);
        num_neg_q <= d_q[15] ^ w_q[43];
      end
      default: begin
      end
    endcase
  end

  `SSTP_ASSERT(a_ready_no_result, !(s_axis_tready_o && m_axis_tvalid_o), "ready with result")
  `SSTP_ASSERT_NXT(a_busy_after_accept, accept, !s_axis_tready_o, "ready after transaction")
  `SSTP_ASSERT(a_single_motion, !(swing_q && turn_q), "swing and turn both running")
  `SSTP_ASSERT_IMP(a_div_done_waiting, div_rsp.done, div_wait, "divider done outside wait")

endmodule

/* tb/servo_swing_turn_profiler_tb.sv */
// Self-checking testbench for the servo swing and turn profiler.
// It drives command transactions, predicts every result with its own profile
// model and checks the output stream; it depends on sstp_pkg and the RTL.
`timescale 1ns / 1ps

module servo_swing_turn_profiler_tb;
  import sstp_pkg::*;

  typedef struct packed {
    logic [15:0] angle;
    logic        active;
  } servo_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  servo_swing_turn_profiler dut (.*);

  // Register copies.
  int unsigned lim_a, lim_b, shape_tri, period_ms, cycles_q88, growth_q412, dir_pos;
  int          amplitude;
  // Motion state copies.
  int unsigned elapsed;
  int          origin_angle, angle_now;
  bit          swinging, turning;
  longint unsigned quarter_wave [0:256];

  servo_result_t pending_results [$];
  int unsigned   error_count, items_sent, results_seen, swings_started, turns_started;
  int unsigned   burst_left, stall_left, cyc;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void build_quarter_wave();
    longint unsigned x, x2, term;
    longint          sum;
    for (int i = 0; i <= 256; i++) begin
      x    = longint'(i) * 64'd3373259426 / 64'd512;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      x = (longint'(sum) + 16384) >> 15;
      quarter_wave[i] = (x > 32768) ? 32768 : x;
    end
  endfunction

  function automatic longint lim_low();
    return (lim_a < lim_b) ? lim_a : lim_b;
  endfunction

  function automatic longint lim_high();
    return (lim_a > lim_b) ? lim_a : lim_b;
  endfunction

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic void advance_swing();
    longint          p, a, g, t, m, d, s;
    longint unsigned total, ph, q, r;
    p     = period_ms;
    a     = amplitude;
    g     = growth_q412;
    t     = elapsed;
    total = longint'(period_ms) * longint'(cycles_q88);
    if (longint'(elapsed) * 256 > total) begin
      swinging = 1'b0;
      t = total >> 8;
    end
    if (p == 0) begin
      swinging  = 1'b0;
      angle_now = origin_angle;
      return;
    end
    m = t % p;
    if (shape_tri == 1) begin
      if (m < p / 4) d = (2 * a * m) / p;
      else if (m < (3 * p) / 4) d = (-2 * a * m) / p + a;
      else d = (2 * a * m) / p - 2 * a;
    end else begin
      ph = (m * 1024) / p;
      q  = ph / 256;
      r  = ph % 256;
      s  = q[0] ? longint'(quarter_wave[256 - r]) : longint'(quarter_wave[r]);
      if (q[1]) s = -s;
      d = ((a / 2) * s) / 32768;
    end
    d = (d * 4096 * p + d * (g - 4096) * t) / (4096 * p);
    if (g < 4096 && t * (4096 - g) > 4096 * p) d = 0;
    if (dir_pos == 0) d = -d;
    angle_now = sat16(d + origin_angle);
  endfunction

  function automatic void advance_turn();
    longint r, a;
    if (period_ms == 0) begin
      turning = 1'b0;
      return;
    end
    r = (longint'(elapsed) * 360) / longint'(period_ms);
    a = (dir_pos != 0) ? origin_angle + r : origin_angle - r;
    if (a < lim_low()) begin
      a = lim_low();
      turning = 1'b0;
    end else if (a > lim_high()) begin
      a = lim_high();
      turning = 1'b0;
    end
    angle_now = int'(a);
  endfunction

  function automatic servo_result_t predict_angle(logic [2:0] cmd, logic [15:0] target);
    longint        tgt;
    servo_result_t res;
    tgt = longint'($signed(target));
    case (cmd)
      CMD_TICK: begin
        if (elapsed != 32'hFFFF_FFFF) elapsed++;
        if (swinging) advance_swing();
        else if (turning) advance_turn();
      end
      CMD_SET_ANGLE: begin
        if (tgt < lim_low()) tgt = lim_low();
        else if (tgt > lim_high()) tgt = lim_high();
        angle_now = int'(tgt);
      end
      CMD_START_SWING: begin
        turning = 1'b0;
        if (!swinging) begin
          swinging     = 1'b1;
          elapsed      = 0;
          origin_angle = angle_now;
        end
      end
      CMD_START_TURN: begin
        swinging     = 1'b0;
        turning      = 1'b1;
        elapsed      = 0;
        origin_angle = angle_now;
      end
      CMD_STOP: begin
        swinging = 1'b0;
        turning  = 1'b0;
      end
      default: ;
    endcase
    res.angle  = angle_now[15:0];
    res.active = swinging | turning;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    servo_result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[15:0] !== want.angle)
          report_mismatch("servo_angle", $signed(m_axis_tdata_o[15:0]), $signed(want.angle));
        if (m_axis_tdata_o[16] !== want.active)
          report_mismatch("motion_active", m_axis_tdata_o[16], want.active);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (cyc[10:8] == 3'd5) begin
      m_axis_tready_i <= 1'b1;
    end else if ($urandom_range(0, 40) == 0) begin
      stall_left      <= $urandom_range(3, 25);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_command(logic [2:0] cmd, logic [15:0] target);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, target, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_angle(cmd, target));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 7);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LOWER_LIMIT:   lim_a       = value[8:0];
      REG_UPPER_LIMIT:   lim_b       = value[8:0];
      REG_WAVE_SHAPE:    shape_tri   = value[0];
      REG_MOTION_PERIOD: period_ms   = value;
      REG_SWING_CYCLES:  cycles_q88  = value;
      REG_SWING_AMP:     amplitude   = $signed(value[12:0]);
      REG_AMP_GROWTH:    growth_q412 = value;
      REG_DIR_POSITIVE:  dir_pos     = value[0];
      default: ;
    endcase
  endtask

  task automatic random_setup(bit long_period);
    write_reg(REG_LOWER_LIMIT, 16'($urandom_range(0, 360) | ($urandom_range(0, 127) << 9)));
    write_reg(REG_UPPER_LIMIT, 16'($urandom_range(0, 360)));
    write_reg(REG_WAVE_SHAPE, 16'($urandom_range(0, 65535)));
    write_reg(REG_MOTION_PERIOD, 16'(long_period ? $urandom_range(0, 65535)
                                                 : $urandom_range(1, 64)));
    write_reg(REG_SWING_CYCLES, 16'(long_period ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 2048)));
    write_reg(REG_SWING_AMP, 16'($urandom_range(0, 65535)));
    write_reg(REG_AMP_GROWTH, 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 8192)
                                                              : $urandom_range(0, 65535)));
    write_reg(REG_DIR_POSITIVE, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_directed();
    write_reg(REG_LOWER_LIMIT, 16'd350);
    write_reg(REG_UPPER_LIMIT, 16'd10);
    write_reg(REG_MOTION_PERIOD, 16'd20);
    write_reg(REG_WAVE_SHAPE, 16'd1);
    write_reg(REG_SWING_AMP, 16'h0FFF);
    send_command(CMD_SET_ANGLE, 16'h7FFF);
    send_command(CMD_SET_ANGLE, 16'h8000);
    send_command(CMD_SET_ANGLE, 16'd100);
    send_command(3'd5, 16'hFFFF);
    send_command(3'd6, 16'd0);
    send_command(3'd7, 16'h1234);
    send_command(CMD_START_SWING, 16'd0);
    repeat (3) send_command(CMD_TICK, 16'd0);
    send_command(CMD_START_SWING, 16'd0);
    send_command(CMD_TICK, 16'd0);
    send_command(CMD_SET_ANGLE, 16'd200);
    send_command(CMD_TICK, 16'd0);
    send_command(CMD_START_TURN, 16'd0);
    repeat (2) send_command(CMD_TICK, 16'd0);
    send_command(CMD_START_SWING, 16'd0);
    send_command(CMD_STOP, 16'd0);
    send_command(CMD_TICK, 16'd0);
    swings_started += 2;
    turns_started++;
    write_reg(REG_MOTION_PERIOD, 16'd0);
    send_command(CMD_START_SWING, 16'd0);
    send_command(CMD_TICK, 16'd0);
    send_command(CMD_START_TURN, 16'd0);
    send_command(CMD_TICK, 16'd0);
  endtask

  task automatic test_extremes();
    write_reg(REG_LOWER_LIMIT, 16'd360);
    write_reg(REG_UPPER_LIMIT, 16'd0);
    write_reg(REG_MOTION_PERIOD, 16'd65535);
    write_reg(REG_SWING_CYCLES, 16'd65535);
    write_reg(REG_AMP_GROWTH, 16'd65535);
    write_reg(REG_SWING_AMP, 16'h1000);
    write_reg(REG_DIR_POSITIVE, 16'd0);
    write_reg(REG_WAVE_SHAPE, 16'd0);
    send_command(CMD_SET_ANGLE, 16'd0);
    send_command(CMD_START_SWING, 16'd0);
    repeat (6) send_command(CMD_TICK, 16'd0);
    send_command(CMD_START_TURN, 16'd0);
    repeat (4) send_command(CMD_TICK, 16'd0);
    write_reg(REG_AMP_GROWTH, 16'd0);
    write_reg(REG_MOTION_PERIOD, 16'd4);
    write_reg(REG_SWING_CYCLES, 16'd2048);
    send_command(CMD_START_SWING, 16'd0);
    repeat (10) send_command(CMD_TICK, 16'd0);
    swings_started += 2;
    turns_started++;
  endtask

  task automatic test_random_motion(int unsigned goal);
    int unsigned kind, ticks;
    while (items_sent < goal) begin
      random_setup($urandom_range(0, 15) == 0);
      repeat ($urandom_range(2, 5)) begin
        kind  = $urandom_range(0, 9);
        ticks = $urandom_range(5, 60);
        if (kind < 8) begin
          send_command(CMD_SET_ANGLE, 16'($urandom_range(0, 65535)));
          send_command((kind < 5) ? CMD_START_SWING : CMD_START_TURN, 16'd0);
          if (kind < 5) swings_started++;
          else turns_started++;
          repeat (ticks) begin
            if ($urandom_range(0, 30) == 0) send_command(3'($urandom_range(0, 7)),
                                                         16'($urandom_range(0, 65535)));
            else send_command(CMD_TICK, 16'($urandom_range(0, 65535)));
          end
          if ($urandom_range(0, 2) == 0) send_command(CMD_STOP, 16'd0);
        end else begin
          repeat ($urandom_range(4, 15))
            send_command(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        end
      end
    end
  endtask

  initial begin
    build_quarter_wave();
    lim_a = 0; lim_b = 180; shape_tri = 0; period_ms = 1000; cycles_q88 = 256;
    amplitude = 0; growth_q412 = 4096; dir_pos = 1;
    elapsed = 0; origin_angle = 0; angle_now = 0; swinging = 0; turning = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_extremes();
    test_random_motion(items_sent + 1050);
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d command transactions and checked %0d results.", items_sent,
             results_seen);
    $display("Motions started: %0d swings and %0d turns.", swings_started, turns_started);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
